[src/cla_pkg.sv]
package cla_pkg;

	// Item operation codes.
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_LOCK   = 2'd1;
	localparam logic [1:0] OP_UNLOCK = 2'd2;

	// Actuator kinds. Any other code behaves as no actuator.
	localparam logic [1:0] TYPE_NONE     = 2'd0;
	localparam logic [1:0] TYPE_MOTOR    = 2'd1;
	localparam logic [1:0] TYPE_SOLENOID = 2'd2;

	// Sequence phases as reported on the phase output.
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_PULSE = 2'd1;
	localparam logic [1:0] PH_WAIT  = 2'd2;

	// Event codes.
	localparam logic [1:0] EV_NONE     = 2'd0;
	localparam logic [1:0] EV_LOCKED   = 2'd1;
	localparam logic [1:0] EV_UNLOCKED = 2'd2;
	localparam logic [1:0] EV_RETRY    = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_LOCK_TYPE   = 2'd0;
	localparam logic [1:0] REG_MOTOR_PULSE = 2'd1;
	localparam logic [1:0] REG_SOL_PULSE   = 2'd2;
	localparam logic [1:0] REG_RETRY_WAIT  = 2'd3;

	// Register reset values.
	localparam logic [15:0] MOTOR_PULSE_RST = 16'd300;
	localparam logic [15:0] SOL_PULSE_RST   = 16'd600;
	localparam logic [15:0] RETRY_WAIT_RST  = 16'd5000;

	typedef struct packed {
		logic [1:0]  lock_type;
		logic [15:0] motor_pulse_ms;
		logic [15:0] solenoid_pulse_ms;
		logic [15:0] retry_wait_ms;
	} cfg_t;

	typedef struct packed {
		logic       drive_a;
		logic       drive_b;
		logic [1:0] phase;
		logic [1:0] event_res;
	} result_t;

endpackage

[src/cla_seq.sv]
module cla_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [1:0]       op,
	input  logic             sense_level,
	input  cla_pkg::cfg_t    cfg,
	output cla_pkg::result_t res
);
	import cla_pkg::*;

	logic        lock_req_q;
	logic [1:0]  phase_q;
	logic [15:0] cnt_q;

	logic        lock_req_d;
	logic [1:0]  phase_d;
	logic [15:0] cnt_d;
	logic [1:0]  event_d;

	logic        type_active;
	logic [15:0] pulse_len;
	logic [15:0] wait_len;
	logic        last_tick;
	logic        sense_ok;

	// Pulse and wait lengths, with a zero length treated as one tick.
	always_comb begin
		type_active = (cfg.lock_type == TYPE_MOTOR) || (cfg.lock_type == TYPE_SOLENOID);
		pulse_len   = (cfg.lock_type == TYPE_MOTOR) ? cfg.motor_pulse_ms
			: cfg.solenoid_pulse_ms;
		if (pulse_len == 16'd0)
			pulse_len = 16'd1;
		wait_len = (cfg.retry_wait_ms == 16'd0) ? 16'd1 : cfg.retry_wait_ms;
		last_tick = (cnt_q <= 16'd1);
		sense_ok  = lock_req_q ? !sense_level : sense_level;
	end

	// Next state and event for the item at the input.
	always_comb begin
		lock_req_d = lock_req_q;
		phase_d    = phase_q;
		cnt_d      = cnt_q;
		event_d    = EV_NONE;
		case (op) inside
			OP_LOCK, OP_UNLOCK: begin
				lock_req_d = (op == OP_LOCK);
				// A command that changes the request restarts the sequence.
				if (lock_req_d != lock_req_q) begin
					phase_d = type_active ? PH_PULSE : PH_IDLE;
					cnt_d   = type_active ? pulse_len : 16'd0;
				end
			end
			OP_TICK: begin
				if (phase_q == PH_PULSE) begin
					if (!last_tick) begin
						cnt_d = cnt_q - 16'd1;
					end else if (sense_ok) begin
						phase_d = PH_IDLE;
						cnt_d   = 16'd0;
						event_d = lock_req_q ? EV_LOCKED : EV_UNLOCKED;
					end else begin
						phase_d = PH_WAIT;
						cnt_d   = wait_len;
						event_d = EV_RETRY;
					end
				end else if (phase_q == PH_WAIT) begin
					if (!last_tick) begin
						cnt_d = cnt_q - 16'd1;
					end else begin
						// The type is checked again before the retry pulse.
						phase_d = type_active ? PH_PULSE : PH_IDLE;
						cnt_d   = type_active ? pulse_len : 16'd0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Result as seen after the item has been applied.
	always_comb begin
		res.drive_a   = (phase_d == PH_PULSE) && lock_req_d;
		res.drive_b   = (phase_d == PH_PULSE) && !lock_req_d;
		res.phase     = phase_d;
		res.event_res = event_d;
	end

	// Sequence state advances once for each accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_req_q <= 1'b0;
			phase_q    <= PH_IDLE;
			cnt_q      <= 16'd0;
		end else if (step) begin
			lock_req_q <= lock_req_d;
			phase_q    <= phase_d;
			cnt_q      <= cnt_d;
		end
	end

endmodule

[src/cable_lock_actuator_retry.sv]
// Cable lock actuator sequencer. Every input item is a 1 ms tick carrying the
// lock-sense level, or a lock or unlock command, and every item yields exactly
// one result item with the drive lines, the phase and an event code. Items are
// taken one per clock cycle while no result stalls: the sequence state and the
// result register update in the cycle the item is accepted, and the result
// register lets a new item in while the previous result is being taken. Configuration
// writes are always accepted and should only be issued while no result is outstanding.
module cable_lock_actuator_retry (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic        sense_level,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        drive_a,
	output logic        drive_b,
	output logic [1:0]  phase,
	output logic [1:0]  event_res,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import cla_pkg::*;

	cfg_t    cfg_q;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    step;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign step      = in_valid && in_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lock_type         <= TYPE_NONE;
			cfg_q.motor_pulse_ms    <= MOTOR_PULSE_RST;
			cfg_q.solenoid_pulse_ms <= SOL_PULSE_RST;
			cfg_q.retry_wait_ms     <= RETRY_WAIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LOCK_TYPE:   cfg_q.lock_type         <= cfg_data[1:0];
				REG_MOTOR_PULSE: cfg_q.motor_pulse_ms    <= cfg_data;
				REG_SOL_PULSE:   cfg_q.solenoid_pulse_ms <= cfg_data;
				REG_RETRY_WAIT:  cfg_q.retry_wait_ms     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	cla_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.op          (op),
		.sense_level (sense_level),
		.cfg         (cfg_q),
		.res         (res)
	);

	// Result register holds the item until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			res_q <= res;
	end

	assign out_valid = out_valid_q;
	assign drive_a   = res_q.drive_a;
	assign drive_b   = res_q.drive_b;
	assign phase     = res_q.phase;
	assign event_res = res_q.event_res;

endmodule

[src/cla_checker.sv]
module cla_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       drive_a,
	input logic       drive_b,
	input logic [1:0] phase,
	input logic [1:0] event_res
);
	import cla_pkg::*;

	// A result that is not taken holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drive_a) && $stable(drive_b)
			&& $stable(phase) && $stable(event_res))
		else $error("result changed while stalled");

	// Only one actuator line is ever driven.
	a_one_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(drive_a && drive_b))
		else $error("both drive lines high");

	// A drive line is high exactly while a pulse runs.
	a_drive_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((drive_a || drive_b) == (phase == PH_PULSE)))
		else $error("drive lines disagree with phase");

	// A retry event always leaves the sequence waiting, a confirmation idle.
	a_event_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (event_res != EV_RETRY || phase == PH_WAIT)
			&& (event_res == EV_RETRY || event_res == EV_NONE || phase == PH_IDLE))
		else $error("event code disagrees with phase");

	// A stalled result blocks new items, so none is lost.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted over a pending result");

endmodule

bind cable_lock_actuator_retry cla_checker u_cla_checker (.*);
